### sv/nds_pkg.sv
// Shared types and constants for the nearest detector search block.
// Used by every module of the block; depends on nothing else.

package nds_pkg;

    localparam int COORD_W           = 24;
    localparam int ENTRY_W           = 6;
    localparam int COUNT_W           = 7;
    localparam int DIST_W            = 25;
    localparam int DIFF_W            = COORD_W + 1;
    localparam int TERM_W            = 2 * COORD_W + 1;
    localparam int ROOT_W            = 25;
    localparam int SQ_W              = 2 * ROOT_W;
    localparam int NUM_DETECTORS_DEF = 64;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } coord_t;

    typedef struct packed {
        logic                      operation;
        logic [ENTRY_W-1:0]        entry_index;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } request_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] nearest_index;
        logic [DIST_W-1:0]  distance;
        logic               no_detector;
    } result_t;

    typedef struct packed {
        logic valid;
        logic last;
    } scan_tag_t;

endpackage

### sv/nds_table.sv
// Centre table: one synchronous memory with one write port and one read port.
// Read data is registered. Depends on nds_pkg.

module nds_table #(
    parameter int NUM_DETECTORS = nds_pkg::NUM_DETECTORS_DEF,
    localparam int ADDR_W = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  nds_pkg::coord_t     wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output nds_pkg::coord_t     rd_data
);
    import nds_pkg::*;

    coord_t centre_mem_reg [NUM_DETECTORS];
    coord_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            centre_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= centre_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/nds_dist.sv
// Squared distance pipeline: absolute differences, squares, then their sum.
// Three register stages; a tag travels alongside each request. Depends on nds_pkg.

module nds_dist (
    input  logic                    clk,
    input  logic                    rst_n,
    input  nds_pkg::coord_t         centre,
    input  nds_pkg::coord_t         point,
    input  nds_pkg::scan_tag_t      tag_in,
    output logic [nds_pkg::SQ_W-1:0] sum,
    output nds_pkg::scan_tag_t      tag_out
);
    import nds_pkg::*;

    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    logic [DIFF_W-1:0]   ad_reg [3];
    logic [DIFF_W-1:0]   ad_next [3];
    logic [TERM_W-1:0]   sq_reg [3];
    logic [TERM_W-1:0]   sq_next [3];
    logic [2*DIFF_W-1:0] prod [3];
    logic [SQ_W-1:0]     sum_reg;
    logic [SQ_W-1:0]     sum_next;
    scan_tag_t           tag1_reg;
    scan_tag_t           tag2_reg;
    scan_tag_t           tag3_reg;

    always_comb
    begin
        ad_next[0] = abs_diff(centre.x, point.x);
        ad_next[1] = abs_diff(centre.y, point.y);
        ad_next[2] = abs_diff(centre.z, point.z);
        for (int k = 0; k < 3; k++)
        begin
            prod[k]    = (2*DIFF_W)'(ad_reg[k]) * (2*DIFF_W)'(ad_reg[k]);
            sq_next[k] = prod[k][TERM_W-1:0];
        end
        sum_next = SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            ad_reg[k] <= ad_next[k];
            sq_reg[k] <= sq_next[k];
        end
        sum_reg <= sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    assign sum     = sum_reg;
    assign tag_out = tag3_reg;

endmodule

### sv/nds_sqrt.sv
// Floor square root, restoring digit-by-digit method, one result bit per cycle.
// Pulses done with the finished root. Depends on nds_pkg.

module nds_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [nds_pkg::SQ_W-1:0]   radicand,
    output logic                       done,
    output logic [nds_pkg::ROOT_W-1:0] root
);
    import nds_pkg::*;

    localparam int REM_W  = ROOT_W + 2;
    localparam int STEP_W = $clog2(ROOT_W);

    logic [SQ_W-1:0]   rad_reg;
    logic [SQ_W-1:0]   rad_next;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              running_reg;
    logic              running_next;
    logic              done_reg;
    logic              done_next;
    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              take;

    always_comb
    begin
        // Bring down the next two radicand bits and try root*4+1.
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[SQ_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        take      = rem_shift >= trial;

        rad_next     = rad_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        step_next    = step_reg;
        running_next = running_reg;
        done_next    = 1'b0;

        if (start)
        begin
            rad_next     = radicand;
            rem_next     = '0;
            root_next    = '0;
            step_next    = '0;
            running_next = 1'b1;
        end
        else if (running_reg)
        begin
            rad_next  = {rad_reg[SQ_W-3:0], 2'b00};
            rem_next  = take ? rem_shift - trial : rem_shift;
            root_next = {root_reg[ROOT_W-2:0], take};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(ROOT_W - 1))
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        step_reg <= step_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### sv/nearest_detector_search.sv
// Nearest detector search: a load request (busy stays low) writes one centre.
// A query with n = min(detector_count, NUM_DETECTORS) centres raises busy,
// reads the centre memory one entry per cycle, and gives its result on done;
// busy falls with done, and the next request can be taken while done is shown.
// It runs the memory scan, the distance pipeline and then the bit-serial square root.
// With a count of zero the result comes the next cycle with no_detector set.
// done is shown for one cycle only; result keeps its value until the next result.
// Depends on nds_pkg, nds_table, nds_dist and nds_sqrt.

module nearest_detector_search #(
    parameter int NUM_DETECTORS = nds_pkg::NUM_DETECTORS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  nds_pkg::request_t            request,
    output logic                         busy,
    output logic                         done,
    output nds_pkg::result_t             result,
    input  logic                         cfg_wen,
    input  logic [nds_pkg::COUNT_W-1:0]  cfg_wdata
);
    import nds_pkg::*;

    localparam int ADDR_W = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;
    localparam int CNT_W  = $clog2(NUM_DETECTORS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_ROOT = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [COUNT_W-1:0] detector_count_reg;
    logic [COUNT_W-1:0] detector_count_next;
    coord_t             point_reg;
    coord_t             point_next;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   n_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  addr_next;
    scan_tag_t          tag_rd_reg;
    scan_tag_t          tag_rd_next;
    logic               first_reg;
    logic               first_next;
    logic [ADDR_W-1:0]  cmp_idx_reg;
    logic [ADDR_W-1:0]  cmp_idx_next;
    logic [ADDR_W-1:0]  best_idx_reg;
    logic [ADDR_W-1:0]  best_idx_next;
    logic [SQ_W-1:0]    best_d_reg;
    logic [SQ_W-1:0]    best_d_next;
    logic               done_reg;
    logic               done_next;
    result_t            result_reg;
    result_t            result_next;

    logic               accept;
    logic               load_en;
    coord_t             req_point;
    logic [CNT_W-1:0]   n_new;
    logic               scan_last;
    coord_t             rd_data;
    logic [SQ_W-1:0]    dist_sum;
    scan_tag_t          dist_tag;
    logic               better;
    logic [SQ_W-1:0]    best_d_new;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [ROOT_W-1:0]  sqrt_root;

    assign accept  = start && (state_reg == ST_IDLE);
    assign load_en = accept && (request.operation == OP_LOAD)
                     && (32'(request.entry_index) < 32'(NUM_DETECTORS));

    assign req_point.x = request.x;
    assign req_point.y = request.y;
    assign req_point.z = request.z;

    assign n_new = (32'(detector_count_reg) > 32'(NUM_DETECTORS))
                   ? CNT_W'(NUM_DETECTORS) : CNT_W'(detector_count_reg);
    assign scan_last = (CNT_W'(addr_reg) + CNT_W'(1)) == n_reg;

    nds_table #(
        .NUM_DETECTORS (NUM_DETECTORS)
    ) u_table (
        .clk     (clk),
        .wr_en   (load_en),
        .wr_addr (ADDR_W'(request.entry_index)),
        .wr_data (req_point),
        .rd_en   (state_reg == ST_SCAN),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    nds_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .centre  (rd_data),
        .point   (point_reg),
        .tag_in  (tag_rd_reg),
        .sum     (dist_sum),
        .tag_out (dist_tag)
    );

    // The first entry always wins; after that only a strictly smaller distance does.
    assign better     = first_reg || (dist_sum < best_d_reg);
    assign best_d_new = better ? dist_sum : best_d_reg;
    assign sqrt_start = dist_tag.valid && dist_tag.last;

    nds_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (best_d_new),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign detector_count_next = cfg_wen ? cfg_wdata : detector_count_reg;

    always_comb
    begin
        state_next    = state_reg;
        point_next    = point_reg;
        n_next        = n_reg;
        addr_next     = addr_reg;
        first_next    = first_reg;
        cmp_idx_next  = cmp_idx_reg;
        best_idx_next = best_idx_reg;
        best_d_next   = best_d_reg;
        done_next     = 1'b0;
        result_next   = result_reg;

        tag_rd_next.valid = (state_reg == ST_SCAN);
        tag_rd_next.last  = scan_last;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (request.operation == OP_QUERY))
                begin
                    point_next = req_point;
                    if (n_new == '0)
                    begin
                        done_next                 = 1'b1;
                        result_next.nearest_index = '0;
                        result_next.distance      = '0;
                        result_next.no_detector   = 1'b1;
                    end
                    else
                    begin
                        state_next   = ST_SCAN;
                        n_next       = n_new;
                        addr_next    = '0;
                        first_next   = 1'b1;
                        cmp_idx_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                addr_next = addr_reg + ADDR_W'(1);
                if (scan_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (sqrt_start)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (sqrt_done)
                begin
                    state_next                = ST_IDLE;
                    done_next                 = 1'b1;
                    result_next.nearest_index = ENTRY_W'(best_idx_reg);
                    result_next.distance      = DIST_W'(sqrt_root);
                    result_next.no_detector   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (dist_tag.valid)
        begin
            first_next   = 1'b0;
            cmp_idx_next = cmp_idx_reg + ADDR_W'(1);
            best_d_next  = best_d_new;
            if (better)
            begin
                best_idx_next = cmp_idx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        point_reg    <= point_next;
        n_reg        <= n_next;
        addr_reg     <= addr_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        best_d_reg   <= best_d_next;
        result_reg   <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            detector_count_reg <= '0;
            tag_rd_reg         <= '0;
            first_reg          <= 1'b0;
            done_reg           <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            detector_count_reg <= detector_count_next;
            tag_rd_reg         <= tag_rd_next;
            first_reg          <= first_next;
            done_reg           <= done_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a query is still running");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result without a query behind it");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.no_detector) |-> ($past(detector_count_reg) == '0))
        else $error("no_detector raised with detectors configured");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CNT_W'(addr_reg) < n_reg))
        else $error("scan read beyond the detector count");

    a_root_start: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |-> (state_reg == ST_WAIT))
        else $error("square root started outside the drain phase");

    a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == ST_ROOT))
        else $error("square root finished while not awaited");
`endif

endmodule
